/* design/assert_macros.svh */
// Assertion macros used by the region table datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled during reset
`define STRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked implication, disabled during reset
`define STRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* design/strt_pkg.sv */
// Shared types, codes and sequence compare functions of the region table
`default_nettype none
package strt_pkg;
  localparam int MAX_REGIONS_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BAD      = 2'd3;

  typedef struct packed {
    logic start;
    logic proc;
    logic fin;
    logic done;
  } strt_cmd_t;

  typedef struct packed {
    logic early;
    logic adv;
    logic stop;
    logic at_end;
    logic out_free;
  } strt_sts_t;

  function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic logic seq_le(input logic [31:0] a, input logic [31:0] b);
    return (a == b) || seq_lt(a, b);
  endfunction
endpackage
`default_nettype wire

/* design/segment_transmit_region_table_core.sv */
// Top level of the segment transmit region table
// Usage:
//   Input channel (in_valid/in_ready) takes one word per operation: record a
//   sent range, look up a sequence, or clear below a point. The result
//   channel (out_valid/out_ready) returns one word per operation with a
//   status and, for a successful lookup, the found region.
//   The table lives in two RAM banks. Each operation streams the current
//   bank entry by entry; a record or clear writes the rewritten table into
//   the other bank, and the banks swap only when the operation succeeds, so a rejected record
//   leaves the table untouched.
//   The scan reads each stored entry and then processes it, since the
//   source bank has a single registered read port; the entry a record
//   splits is processed further before the scan moves on. A lookup stops at
//   the first entry past the sequence, and bad inputs skip the scan. One
//   operation is in flight at a time; in_ready is high only while the scan
//   sequencer is idle.
//   A finished result sits in the output register while the next word is
//   accepted and scanned; if the receiver stalls, the next result waits
//   until the output register is free.
//   Reset empties the table at once; no clearing pass is needed.
`default_nettype none
module segment_transmit_region_table_core #(
  parameter int MAX_REGIONS = strt_pkg::MAX_REGIONS_DEF,
  parameter int COUNT_WIDTH = strt_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_seq_begin,
  input  wire logic [31:0] in_seq_end,
  input  wire logic [62:0] in_sent_time,
  input  wire logic [31:0] in_query_seq,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_found_begin,
  output logic [31:0]      out_found_end,
  output logic [62:0]      out_found_first_time,
  output logic [62:0]      out_found_last_time,
  output logic [15:0]      out_found_count
);
  import strt_pkg::*;

  strt_cmd_t cmd;
  strt_sts_t sts;

  strt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  strt_dp #(.MAX_REGIONS(MAX_REGIONS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_operation(in_operation), .in_seq_begin(in_seq_begin),
    .in_seq_end(in_seq_end), .in_sent_time(in_sent_time),
    .in_query_seq(in_query_seq),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_found_begin(out_found_begin), .out_found_end(out_found_end),
    .out_found_first_time(out_found_first_time),
    .out_found_last_time(out_found_last_time),
    .out_found_count(out_found_count)
  );
endmodule
`default_nettype wire

/* design/strt_ram.sv */
// Generic single write port RAM with registered read
`default_nettype none
module strt_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/strt_ctrl.sv */
// Controller state machine sequencing the entry scan of one operation
`default_nettype none
module strt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire strt_pkg::strt_sts_t sts,
  output strt_pkg::strt_cmd_t      cmd
);
  import strt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_PROC, S_FIN, S_DONE} state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = sts.early ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        state_nxt = sts.at_end ? S_FIN : S_PROC;
      end
      S_PROC: begin
        cmd.proc = 1'b1;
        if (sts.stop) begin
          state_nxt = S_DONE;
        end else if (sts.adv) begin
          state_nxt = S_READ;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

/* design/strt_dp.sv */
// Datapath: table banks, entry scan, rewrite stream and result register
`default_nettype none
module strt_dp #(
  parameter int MAX_REGIONS = strt_pkg::MAX_REGIONS_DEF,
  parameter int COUNT_WIDTH = strt_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire strt_pkg::strt_cmd_t cmd,
  output strt_pkg::strt_sts_t      sts,
  input  wire logic [1:0]          in_operation,
  input  wire logic [31:0]         in_seq_begin,
  input  wire logic [31:0]         in_seq_end,
  input  wire logic [62:0]         in_sent_time,
  input  wire logic [31:0]         in_query_seq,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_status,
  output logic [31:0]              out_found_begin,
  output logic [31:0]              out_found_end,
  output logic [62:0]              out_found_first_time,
  output logic [62:0]              out_found_last_time,
  output logic [15:0]              out_found_count
);
  import strt_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = COUNT_WIDTH;
  localparam int W  = 32 + 32 + 63 + 63 + CW;
  localparam int AW = $clog2(MAX_REGIONS);
  localparam int NW = $clog2(MAX_REGIONS + 1);
  localparam logic [NW-1:0] NMAX = NW'(MAX_REGIONS);

  typedef enum logic [2:0] {M_GEN, M_APP, M_PRE, M_LOOK, M_CLR} mode_t;
  typedef enum logic [1:0] {P_PRE, P_MID, P_POST} phase_t;

  logic [31:0] b_r, e_r, q_r, cur_r, eb_r, fb_r, lae_r, dfb_r, dle_r;
  logic [62:0] t_r;
  mode_t mode_r;
  phase_t ph_r;
  logic ebmod_r, ovf_r, bad_r, found_r, sel_r, outv_r;
  logic [NW-1:0] k_r, wptr_r, n_r;
  logic [31:0] fnd_b_r, fnd_e_r;
  logic [62:0] fnd_f_r, fnd_l_r;
  logic [CW-1:0] fnd_c_r;

  logic [W-1:0] rd0, rd1, rd, wword;
  logic [31:0] rb, re;
  logic [62:0] rf, rl;
  logic [CW-1:0] rc;

  assign rd = sel_r ? rd1 : rd0;
  assign {rb, re, rf, rl, rc} = rd;

  logic [31:0] eb;
  logic [62:0] mn, mx;
  logic [CW-1:0] inc;
  assign eb  = ebmod_r ? eb_r : rb;
  assign mn  = (rf > t_r) ? t_r : rf;
  assign mx  = (rl < t_r) ? t_r : rl;
  assign inc = (rc == '1) ? rc : rc + CW'(1);

  logic emit, adv, stop, bad_now, fnd_now, early;
  logic [31:0] w_b, w_e;
  logic [62:0] w_f, w_l;
  logic [CW-1:0] w_c;
  logic [31:0] cur_nxt, eb_nxt;
  logic ebmod_nxt;
  phase_t ph_nxt;
  mode_t st_mode;

  always_comb begin
    emit = 1'b0; adv = 1'b0; stop = 1'b0; bad_now = 1'b0; fnd_now = 1'b0;
    w_b = eb; w_e = re; w_f = rf; w_l = rl; w_c = rc;
    cur_nxt = cur_r; eb_nxt = eb_r; ebmod_nxt = ebmod_r; ph_nxt = ph_r;
    early = 1'b0; st_mode = M_GEN;
    if (cmd.start) begin
      case (in_operation)
        OP_RECORD: begin
          if (!seq_lt(in_seq_begin, in_seq_end)) begin
            early = 1'b1; bad_now = 1'b1;
          end else if (n_r != '0 && !(seq_le(fb_r, in_seq_begin) &&
                                      seq_le(in_seq_begin, lae_r))) begin
            early = 1'b1; bad_now = 1'b1;
          end else if (n_r == '0 || lae_r == in_seq_begin) begin
            st_mode = M_APP;
          end else if (in_seq_end == fb_r) begin
            st_mode = M_PRE;
            emit = 1'b1;
            w_b = in_seq_begin; w_e = in_seq_end;
            w_f = in_sent_time; w_l = in_sent_time; w_c = CW'(1);
          end else begin
            st_mode = M_GEN;
          end
        end
        OP_LOOKUP: st_mode = M_LOOK;
        OP_CLEAR:  st_mode = M_CLR;
        default: begin
          early = 1'b1; bad_now = 1'b1;
        end
      endcase
    end else if (cmd.proc) begin
      case (mode_r)
        M_APP, M_PRE: begin
          emit = 1'b1; adv = 1'b1;
        end
        M_LOOK: begin
          if (seq_lt(q_r, rb)) begin
            stop = 1'b1;
          end else if (seq_lt(q_r, re)) begin
            stop = 1'b1; fnd_now = 1'b1;
          end else begin
            adv = 1'b1;
          end
        end
        M_CLR: begin
          adv = 1'b1;
          if (ph_r == P_PRE) begin
            if (!seq_le(re, q_r)) begin
              emit = 1'b1; ph_nxt = P_POST;
              w_b = seq_lt(rb, q_r) ? q_r : rb;
            end
          end else begin
            emit = 1'b1;
          end
        end
        default: begin
          case (ph_r)
            P_PRE: begin
              if (seq_le(re, b_r)) begin
                emit = 1'b1; adv = 1'b1;
              end else if (!seq_le(eb, b_r)) begin
                bad_now = 1'b1; stop = 1'b1;
              end else begin
                ph_nxt = P_MID;
                if (b_r != eb) begin
                  emit = 1'b1; w_e = b_r;
                  eb_nxt = b_r; ebmod_nxt = 1'b1;
                end
              end
            end
            P_MID: begin
              if (seq_le(re, e_r)) begin
                if (eb != cur_r) begin
                  bad_now = 1'b1; stop = 1'b1;
                end else begin
                  emit = 1'b1; adv = 1'b1;
                  w_f = mn; w_l = mx; w_c = inc; cur_nxt = re;
                end
              end else if (cur_r != e_r) begin
                if (eb != cur_r) begin
                  bad_now = 1'b1; stop = 1'b1;
                end else begin
                  emit = 1'b1; w_b = cur_r; w_e = e_r;
                  w_f = mn; w_l = mx; w_c = inc;
                  eb_nxt = e_r; ebmod_nxt = 1'b1; ph_nxt = P_POST;
                end
              end else begin
                ph_nxt = P_POST;
              end
            end
            default: begin
              emit = 1'b1; adv = 1'b1;
            end
          endcase
        end
      endcase
      if (adv) begin
        ebmod_nxt = 1'b0;
      end
    end else if (cmd.fin) begin
      w_b = cur_r; w_e = e_r; w_f = t_r; w_l = t_r; w_c = CW'(1);
      if (mode_r == M_APP) begin
        emit = 1'b1; w_b = b_r;
      end else if (mode_r == M_GEN) begin
        if (ph_r == P_PRE) begin
          bad_now = 1'b1;
        end else if (ph_r == P_MID && cur_r != e_r) begin
          emit = 1'b1;
        end
      end
    end
  end

  assign wword = {w_b, w_e, w_f, w_l, w_c};
  logic wr_ok;
  logic [NW-1:0] wbase;
  assign wbase = cmd.start ? '0 : wptr_r;
  assign wr_ok = emit && (wbase != NMAX);

  strt_ram #(.W(W), .D(MAX_REGIONS)) u_bank0 (
    .clk(clk), .we(wr_ok && sel_r), .waddr(wbase[AW-1:0]), .wdata(wword),
    .raddr(k_r[AW-1:0]), .rdata(rd0)
  );
  strt_ram #(.W(W), .D(MAX_REGIONS)) u_bank1 (
    .clk(clk), .we(wr_ok && !sel_r), .waddr(wbase[AW-1:0]), .wdata(wword),
    .raddr(k_r[AW-1:0]), .rdata(rd1)
  );

  assign sts.early    = early;
  assign sts.adv      = adv;
  assign sts.stop     = stop;
  assign sts.at_end   = (k_r == n_r);
  assign sts.out_free = !outv_r || out_ready;

  logic [1:0] fin_st;
  logic commit;
  always_comb begin
    commit = 1'b0;
    if (bad_r) begin
      fin_st = ST_BAD;
    end else if (mode_r == M_LOOK) begin
      fin_st = found_r ? ST_OK : ST_NOTFOUND;
    end else if (ovf_r) begin
      fin_st = ST_FULL;
    end else begin
      fin_st = ST_OK; commit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0; sel_r <= 1'b0; outv_r <= 1'b0;
      k_r <= '0; wptr_r <= '0; ovf_r <= 1'b0; bad_r <= 1'b0; found_r <= 1'b0;
      mode_r <= M_GEN; ph_r <= P_PRE; ebmod_r <= 1'b0;
    end else begin
      if (out_ready) begin
        outv_r <= 1'b0;
      end
      cur_r <= cur_nxt; eb_r <= eb_nxt; ebmod_r <= ebmod_nxt; ph_r <= ph_nxt;
      if (emit) begin
        if (wr_ok) begin
          wptr_r <= wbase + NW'(1);
          if (wbase == '0) begin
            dfb_r <= w_b;
          end
          dle_r <= w_e;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (adv) begin
        k_r <= k_r + NW'(1);
      end
      if (bad_now) begin
        bad_r <= 1'b1;
      end
      if (fnd_now) begin
        found_r <= 1'b1;
        fnd_b_r <= rb; fnd_e_r <= re; fnd_f_r <= rf; fnd_l_r <= rl; fnd_c_r <= rc;
      end
      if (cmd.start) begin
        b_r <= in_seq_begin; e_r <= in_seq_end; t_r <= in_sent_time;
        q_r <= in_query_seq; mode_r <= st_mode; ph_r <= P_PRE;
        cur_r <= in_seq_begin; ebmod_r <= 1'b0; k_r <= '0;
        ovf_r <= 1'b0; bad_r <= bad_now; found_r <= 1'b0;
        if (!emit) begin
          wptr_r <= '0;
        end
      end
      if (cmd.done) begin
        outv_r <= 1'b1;
        out_status <= fin_st;
        out_found_begin <= '0; out_found_end <= '0;
        out_found_first_time <= '0; out_found_last_time <= '0;
        out_found_count <= '0;
        if (mode_r == M_LOOK && found_r && !bad_r) begin
          out_found_begin <= fnd_b_r; out_found_end <= fnd_e_r;
          out_found_first_time <= fnd_f_r; out_found_last_time <= fnd_l_r;
          out_found_count <= 16'(fnd_c_r);
        end
        if (commit && mode_r != M_LOOK) begin
          sel_r <= !sel_r; n_r <= wptr_r; fb_r <= dfb_r; lae_r <= dle_r;
        end
      end
    end
  end

  assign out_valid = outv_r;

  `STRT_ASSERT(a_n_bound, n_r <= NMAX, "entry count beyond table size")
  `STRT_ASSERT(a_w_bound, wptr_r <= NMAX, "write pointer beyond table size")
  `STRT_ASSERT_IMP(a_stop_done, cmd.proc && stop, !cmd.proc,
    "scan continued after it stopped")
endmodule
`default_nettype wire
